[sv/gfl_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gfl_pkg
// Constants, types and the CORDIC arctangent table for the GPS fix to local
// offset block. Angles and trig values are Q60 radians.
// ----------------------------------------------------------------------------
package gfl_pkg;

  localparam logic [63:0] PI_Q60     = 64'h3243F6A8885A308D;
  localparam logic [63:0] GAIN_K     = 64'd700114967507363238;
  localparam logic [24:0] PI_FILE_E7 = 25'd31415926;
  localparam logic [54:0] RAD_DEN    = 55'd18000000000000000;
  localparam logic [54:0] RAD_DEN2   = 55'd36000000000000000;
  localparam logic [63:0] RADIUS_MM  = 64'd6378137000;
  localparam logic [35:0] SAT_MM     = 36'd20100000000;
  localparam logic [30:0] QUARTER_E7 = 31'd900000000;
  localparam logic [30:0] HALF_E7    = 31'd1800000000;
  localparam logic [32:0] QUARTER2   = 33'd1800000000;
  localparam logic [32:0] HALF2      = 33'd3600000000;

  // m*pi_e7*2^60/1.8e16 = m*PI_HALF_E7*2^45/RAD_D (2^44 for the half angle)
  localparam logic [23:0] PI_HALF_E7 = 24'd15707963;
  localparam logic [63:0] RAD_D      = 64'd274658203125;
  // floor(2^(s+56)/RAD_D): estimate is within one of the rounded quotient
  localparam logic [63:0] RECIP_45   = 64'((128'd1 << 101) / 128'd274658203125);
  localparam logic [63:0] RECIP_44   = 64'((128'd1 << 100) / 128'd274658203125);

  localparam logic [2:0] MUL_LAST  = 3'd5;

  localparam int ROM_DEPTH = 64;
  localparam int ROM_AW    = 6;

  typedef logic [63:0] atan_rom_t [ROM_DEPTH];

  typedef enum logic [4:0] {
    ST_IDLE = 5'b00001,
    ST_LOAD = 5'b00010,
    ST_MUL  = 5'b00100,
    ST_CORD = 5'b01000,
    ST_OUT  = 5'b10000
  } state_t;

  typedef enum logic [3:0] {
    SP_N_EST = 4'd0,
    SP_N_CHK = 4'd1,
    SP_N_MUL = 4'd2,
    SP_F_EST = 4'd3,
    SP_F_CHK = 4'd4,
    SP_F_ROT = 4'd5,
    SP_H_EST = 4'd6,
    SP_H_CHK = 4'd7,
    SP_H_ROT = 4'd8,
    SP_P_MUL = 4'd9,
    SP_R_MUL = 4'd10,
    SP_R_VEC = 4'd11,
    SP_Q_MUL = 4'd12,
    SP_A_VEC = 4'd13,
    SP_E_MUL = 4'd14
  } step_t;

  // atan(2^-i) in Q60 from the alternating series; entry 0 is pi/4
  function automatic atan_rom_t atan_rom_build();
    atan_rom_t   rom;
    logic [63:0] sum;
    logic [63:0] term;
    int          e;
    for (int i = 0; i < ROM_DEPTH; i++) begin
      if (i == 0) begin
        rom[i] = (PI_Q60 + 64'd2) >> 2;
      end else begin
        sum = '0;
        for (int k = 0; k < 32; k++) begin
          e = i * (2 * k + 1);
          if (e <= 62) begin
            term = (64'd1 << (62 - e)) / 64'(2 * k + 1);
            if (k % 2 == 1) begin
              sum = sum - term;
            end else begin
              sum = sum + term;
            end
          end
        end
        rom[i] = (sum + 64'd2) >> 2;
      end
    end
    return rom;
  endfunction

  localparam atan_rom_t ATAN_ROM = atan_rom_build();

endpackage

[sv/gps_fix_to_local_offset_top.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gps_fix_to_local_offset_top
// GPS fix to local north/east offset in millimetres from the first fix.
// ----------------------------------------------------------------------------
// The first fix after reset is latched as the origin and gives no word.
// Every later fix gives one word with north and east offsets, saturated
// to +-20100000000 mm. One fix at a time: a fix runs eleven 64x64
// products built from 32x32 partial products (a reciprocal estimate and a
// correction product for each of the three degree to radian conversions,
// then five more), a load state ahead of each of the fifteen steps, and
// four passes through one shared CORDIC unit at one iteration per cycle.
// The result word is held in an output register until taken.
module gps_fix_to_local_offset_top
  import gfl_pkg::*;
#(
  parameter int CORDIC_ITERATIONS = 32
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               fix_valid,
  output logic               fix_stall,
  input  logic signed [30:0] latitude_e7,
  input  logic signed [31:0] longitude_e7,
  output logic               offset_valid,
  input  logic               offset_stall,
  output logic signed [35:0] north_mm,
  output logic signed [35:0] east_mm
);

  localparam logic [ROM_AW-1:0] COR_LAST = ROM_AW'(CORDIC_ITERATIONS - 1);

  state_t state;
  step_t  step;

  logic        origin_valid;
  logic [30:0] origin_lat;
  logic [31:0] origin_lon;
  logic [31:0] dlat_mag;
  logic [30:0] lat_red;
  logic [32:0] dlon_red;
  logic        north_pos;
  logic        east_pos;

  logic [54:0] rad_num;

  logic [63:0]  mul_a;
  logic [63:0]  mul_b;
  logic [63:0]  mul_pp;
  logic [1:0]   mul_off;
  logic [127:0] mul_acc;
  logic [2:0]   mul_cnt;
  logic         mul_s59;
  logic         mul_s56;

  logic signed [63:0] cx;
  logic signed [63:0] cy;
  logic signed [63:0] cz;
  logic               c_vec;
  logic [ROM_AW-1:0]  c_cnt;

  logic [63:0] t0, cf, sf, ch, sh, pv, rv;
  logic [63:0] north_mag, east_mag;

  function automatic logic [63:0] abs64(input logic signed [63:0] v);
    return v[63] ? 64'(-v) : 64'(v);
  endfunction

  function automatic logic [35:0] sat_sign(input logic [63:0] mag, input logic pos);
    logic [35:0] v;
    v = (mag > 64'(SAT_MM)) ? SAT_MM : mag[35:0];
    return pos ? v : 36'(-v);
  endfunction

  // fix decode
  logic signed [31:0] dlat;
  logic signed [32:0] dlon;
  logic [30:0]        lat_abs;
  logic [32:0]        dlon_abs;
  logic [32:0]        dlon_fold;

  always_comb begin
    dlat     = 32'($signed(latitude_e7)) - 32'($signed(origin_lat));
    dlon     = 33'($signed(longitude_e7)) - 33'($signed(origin_lon));
    lat_abs  = latitude_e7[30] ? 31'(-latitude_e7) : 31'(latitude_e7);
    dlon_abs = dlon[32] ? 33'(-dlon) : 33'(dlon);
    if (dlon_abs > QUARTER2) begin
      dlon_fold = (dlon_abs <= HALF2) ? HALF2 - dlon_abs : dlon_abs - HALF2;
    end else begin
      dlon_fold = dlon_abs;
    end
  end

  // multiplier step
  logic [127:0] acc_sum;
  logic [127:0] mul_rnd;
  logic [63:0]  mul_res;

  always_comb begin
    acc_sum = mul_acc + ({64'd0, mul_pp} << (7'd32 * 7'(mul_off)));
    mul_rnd = mul_acc + (mul_s56 ? (128'd1 << 55) :
                         mul_s59 ? (128'd1 << 58) : (128'd1 << 59));
    mul_res = mul_s56 ? mul_rnd[119:56] :
              mul_s59 ? mul_rnd[122:59] : mul_rnd[123:60];
  end

  // CORDIC step
  logic               c_dir;
  logic signed [63:0] cxn, cyn, czn;
  logic [63:0]        c_atan;

  always_comb begin
    c_atan = ATAN_ROM[c_cnt];
    c_dir  = c_vec ? (cy[63] || cy == 64'sd0) : !cz[63];
    if (c_dir) begin
      cxn = cx - (cy >>> c_cnt);
      cyn = cy + (cx >>> c_cnt);
      czn = cz - $signed(c_atan);
    end else begin
      cxn = cx + (cy >>> c_cnt);
      cyn = cy - (cx >>> c_cnt);
      czn = cz + $signed(c_atan);
    end
  end

  logic [32:0] div_src;
  always_comb begin
    case (step)
      SP_N_EST: div_src = {1'b0, dlat_mag};
      SP_F_EST: div_src = {2'b0, lat_red};
      default:  div_src = dlon_red;
    endcase
  end

  // radian conversion: scaled angle and the bound for the rounding check
  logic [54:0]  rad_m;
  logic [127:0] chk_rhs;

  always_comb begin
    rad_m   = 55'(55'(div_src) * 55'(PI_HALF_E7));
    chk_rhs = (step == SP_H_CHK) ? {28'd0, rad_num, 45'd0} : {27'd0, rad_num, 46'd0};
  end

  assign fix_stall = state != ST_IDLE;

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= ST_IDLE;
      step         <= SP_N_EST;
      origin_valid <= 1'b0;
      origin_lat   <= '0;
      origin_lon   <= '0;
      offset_valid <= 1'b0;
    end else begin
      if (offset_valid && !offset_stall && state != ST_OUT) begin
        offset_valid <= 1'b0;
      end
      case (state)
        ST_IDLE: begin
          if (fix_valid) begin
            if (!origin_valid) begin
              origin_valid <= 1'b1;
              origin_lat   <= latitude_e7;
              origin_lon   <= longitude_e7;
            end else begin
              dlat_mag  <= dlat[31] ? 32'(-dlat) : 32'(dlat);
              lat_red   <= (lat_abs > QUARTER_E7) ? HALF_E7 - lat_abs : lat_abs;
              dlon_red  <= dlon_fold;
              north_pos <= !dlat[31] && dlat != 32'sd0;
              east_pos  <= !dlon[32] && dlon != 33'sd0;
              step      <= SP_N_EST;
              state     <= ST_LOAD;
            end
          end
        end
        ST_LOAD: begin
          case (step)
            SP_F_ROT, SP_H_ROT, SP_R_VEC, SP_A_VEC: begin
              c_vec <= (step == SP_R_VEC) || (step == SP_A_VEC);
              case (step)
                SP_R_VEC: begin
                  cx <= $signed(rv);
                  cy <= $signed(sf);
                  cz <= '0;
                end
                SP_A_VEC: begin
                  cx <= $signed(t0);
                  cy <= $signed(pv);
                  cz <= '0;
                end
                default: begin
                  cx <= $signed(GAIN_K);
                  cy <= '0;
                  cz <= $signed(t0);
                end
              endcase
              c_cnt <= '0;
              state <= ST_CORD;
            end
            default: begin
              case (step)
                SP_N_EST, SP_F_EST, SP_H_EST: begin
                  mul_a   <= 64'(rad_m);
                  mul_b   <= (step == SP_H_EST) ? RECIP_44 : RECIP_45;
                  rad_num <= rad_m;
                end
                SP_N_CHK, SP_F_CHK, SP_H_CHK: begin
                  mul_a <= {t0[62:0], 1'b1};
                  mul_b <= RAD_D;
                end
                SP_P_MUL: begin
                  mul_a <= cf;
                  mul_b <= sh;
                end
                SP_R_MUL: begin
                  mul_a <= cf;
                  mul_b <= ch;
                end
                SP_Q_MUL: begin
                  mul_a <= t0;
                  mul_b <= GAIN_K;
                end
                default: begin
                  mul_a <= t0;
                  mul_b <= RADIUS_MM;
                end
              endcase
              mul_s56 <= step inside {SP_N_EST, SP_F_EST, SP_H_EST};
              mul_s59 <= step == SP_E_MUL;
              mul_acc <= '0;
              mul_cnt <= '0;
              state   <= ST_MUL;
            end
          endcase
        end
        ST_MUL: begin
          if (mul_cnt < 3'd4) begin
            mul_pp  <= (mul_cnt[0] ? mul_a[63:32] : mul_a[31:0]) *
                       (mul_cnt[1] ? mul_b[63:32] : mul_b[31:0]);
            mul_off <= 2'(mul_cnt[0]) + 2'(mul_cnt[1]);
          end
          if (mul_cnt >= 3'd1 && mul_cnt <= 3'd4) begin
            mul_acc <= acc_sum;
          end
          mul_cnt <= mul_cnt + 3'd1;
          if (mul_cnt == MUL_LAST) begin
            case (step)
              SP_N_EST, SP_F_EST, SP_H_EST: t0 <= mul_res;
              SP_N_CHK, SP_F_CHK, SP_H_CHK: begin
                // estimate one low when (2q+1)*d still fits under twice the numerator
                if (mul_acc <= chk_rhs) begin
                  t0 <= t0 + 64'd1;
                end
              end
              SP_N_MUL: north_mag <= mul_res;
              SP_P_MUL: pv        <= mul_res;
              SP_R_MUL: rv        <= mul_res;
              SP_Q_MUL: t0        <= mul_res;
              default:  east_mag  <= mul_res;
            endcase
            if (step == SP_E_MUL) begin
              state <= ST_OUT;
            end else begin
              step  <= step_t'(step + 4'd1);
              state <= ST_LOAD;
            end
          end
        end
        ST_CORD: begin
          cx    <= cxn;
          cy    <= cyn;
          cz    <= czn;
          c_cnt <= c_cnt + ROM_AW'(1);
          if (c_cnt == COR_LAST) begin
            case (step)
              SP_F_ROT: begin
                cf <= abs64(cxn);
                sf <= abs64(cyn);
              end
              SP_H_ROT: begin
                ch <= abs64(cxn);
                sh <= abs64(cyn);
              end
              SP_R_VEC: t0 <= abs64(cxn);
              default:  t0 <= czn[63] ? 64'd0 : 64'(czn);
            endcase
            step  <= step_t'(step + 4'd1);
            state <= ST_LOAD;
          end
        end
        ST_OUT: begin
          if (!offset_valid || !offset_stall) begin
            north_mm     <= sat_sign(north_mag, north_pos);
            east_mm      <= sat_sign(east_mag, east_pos);
            offset_valid <= 1'b1;
            state        <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

endmodule

[bench/gfl_offset_checker.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gfl_offset_checker
// Watches both channels of the GPS offset block, predicts every offset word
// from the accepted fixes with a fixed point CORDIC model and compares.
// ----------------------------------------------------------------------------
module gfl_offset_checker #(
  parameter int ITERS = 32
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               fix_valid,
  input  logic               fix_stall,
  input  logic signed [30:0] latitude_e7,
  input  logic signed [31:0] longitude_e7,
  input  logic               offset_valid,
  input  logic               offset_stall,
  input  logic signed [35:0] north_mm,
  input  logic signed [35:0] east_mm,
  output int                 errors,
  output int                 pending
);
  import gfl_pkg::*;

  typedef struct packed {
    logic signed [35:0] north;
    logic signed [35:0] east;
  } offset_t;

  offset_t        offsets_due[$];
  longint         atan_tab[64];
  bit             have_origin;
  longint         origin_lat;
  longint         origin_lon;

  function automatic longint atan_entry(int i);
    longint unsigned sum;
    longint unsigned e;
    sum = 0;
    if (i == 0) return longint'((PI_Q60 + 64'd2) >> 2);
    for (int k = 0; ; k++) begin
      e = i * (2 * k + 1);
      if (e > 62) break;
      if (k % 2 == 1) sum -= (64'd1 << (62 - e)) / (2 * k + 1);
      else sum += (64'd1 << (62 - e)) / (2 * k + 1);
    end
    return longint'((sum + 2) >> 2);
  endfunction

  function automatic longint mag(longint v);
    return v < 0 ? -v : v;
  endfunction

  function automatic longint unsigned mul_round(longint unsigned a, longint unsigned b,
                                                int s);
    logic [127:0] p;
    p = 128'(a) * 128'(b) + (128'd1 << (s - 1));
    return 64'(p >> s);
  endfunction

  function automatic longint unsigned rad_q60(longint unsigned num, longint unsigned den);
    logic [127:0] ip, r, f;
    ip = num / den;
    r  = num % den;
    f  = (r << 61) / den;
    return 64'((ip << 60) + ((f + 1) >> 1));
  endfunction

  task automatic rotate(input longint z, output longint c, output longint s);
    longint x, y, dx, dy;
    x = longint'(GAIN_K);
    y = 0;
    for (int i = 0; i < ITERS; i++) begin
      dx = y >>> i;
      dy = x >>> i;
      if (z >= 0) begin
        x -= dx; y += dy; z -= atan_tab[i];
      end else begin
        x += dx; y -= dy; z += atan_tab[i];
      end
    end
    c = mag(x);
    s = mag(y);
  endtask

  task automatic vector(input longint x, input longint y, output longint xo,
                        output longint zo);
    longint z, dx, dy;
    z = 0;
    for (int i = 0; i < ITERS; i++) begin
      dx = y >>> i;
      dy = x >>> i;
      if (y > 0) begin
        x += dx; y -= dy; z += atan_tab[i];
      end else begin
        x -= dx; y += dy; z -= atan_tab[i];
      end
    end
    xo = mag(x);
    zo = z < 0 ? 0 : z;
  endtask

  function automatic logic signed [35:0] clamp(longint unsigned m, bit pos);
    longint v;
    v = m > longint'(SAT_MM) ? longint'(SAT_MM) : longint'(m);
    return 36'(pos ? v : -v);
  endfunction

  task automatic predict_offset(input longint lat, input longint lon);
    longint dlat, dlon, m, cf, sf, ch, sh, x1, ang, q;
    longint unsigned t, p, r, nmag, emag;
    offset_t o;
    dlat = lat - origin_lat;
    nmag = mul_round(rad_q60(mag(dlat) * PI_FILE_E7, RAD_DEN), RADIUS_MM, 60);
    m = mag(lat);
    if (m > QUARTER_E7) m = HALF_E7 - m;
    rotate(longint'(rad_q60(m * PI_FILE_E7, RAD_DEN)), cf, sf);
    dlon = lon - origin_lon;
    t = mag(dlon);
    if (t > QUARTER2) t = (t <= HALF2) ? HALF2 - t : t - HALF2;
    rotate(longint'(rad_q60(t * PI_FILE_E7, RAD_DEN2)), ch, sh);
    p = mul_round(cf, sh, 60);
    r = mul_round(cf, ch, 60);
    vector(longint'(r), sf, x1, ang);
    q = longint'(mul_round(x1, GAIN_K, 60));
    vector(q, longint'(p), x1, ang);
    emag = mul_round(ang, RADIUS_MM, 59);
    o.north = clamp(nmag, dlat > 0);
    o.east  = clamp(emag, dlon > 0);
    offsets_due = {offsets_due, o};
  endtask

  task automatic report(string what, longint got, longint want);
    $display("mismatch %s: got %0d expected %0d at %0t", what, got, want, $realtime);
    errors++;
  endtask

  initial begin
    errors = 0;
    for (int i = 0; i < 64; i++) atan_tab[i] = atan_entry(i);
  end

  always @(posedge clk) begin
    offset_t want;
    if (rst) begin
      have_origin <= 1'b0;
      offsets_due.delete();
    end else begin
      if (offset_valid && !offset_stall) begin
        if (offsets_due.size() == 0) begin
          report("unexpected word north", north_mm, 0);
        end else begin
          want = offsets_due.pop_front();
          if (north_mm !== want.north) report("north_mm", north_mm, want.north);
          if (east_mm !== want.east) report("east_mm", east_mm, want.east);
        end
      end
      if (fix_valid && !fix_stall) begin
        if (!have_origin) begin
          have_origin <= 1'b1;
          origin_lat  <= latitude_e7;
          origin_lon  <= longitude_e7;
        end else begin
          predict_offset(latitude_e7, longitude_e7);
        end
      end
    end
    pending = offsets_due.size();
  end

endmodule

[bench/tb_gps_fix_to_local_offset_top.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_gps_fix_to_local_offset_top
// Drives GPS fixes into the offset block with random gaps and output stalls;
// a checker beside the block predicts and compares every offset word.
// ----------------------------------------------------------------------------
module tb_gps_fix_to_local_offset_top;

  logic               clk = 1'b0;
  logic               rst = 1'b1;
  logic               fix_valid = 1'b0;
  logic               fix_stall;
  logic signed [30:0] latitude_e7 = '0;
  logic signed [31:0] longitude_e7 = '0;
  logic               offset_valid;
  logic               offset_stall = 1'b0;
  logic signed [35:0] north_mm;
  logic signed [35:0] east_mm;
  int                 errors;
  int                 pending;
  bit                 long_hold_req = 1'b0;

  always #2 clk = ~clk;

  gps_fix_to_local_offset_top uut (.*);

  gfl_offset_checker chk (.*);

  task automatic send_fix(input longint lat, input longint lon);
    int gap;
    gap = $urandom_range(0, 8);
    if (gap > 0) begin
      fix_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    fix_valid    <= 1'b1;
    latitude_e7  <= 31'(lat);
    longitude_e7 <= 32'(lon);
    do @(posedge clk); while (fix_stall);
  endtask

  function automatic longint srand(longint lim);
    return longint'($urandom_range(0, 2 * lim)) - lim;
  endfunction

  // receiver: random hold after each word, one long hold on request
  always @(posedge clk) begin
    int n;
    static int hold = 0;
    if (rst) begin
      offset_stall <= 1'b0;
    end else if (hold > 0) begin
      hold--;
      offset_stall <= 1'b1;
    end else if (offset_valid && !offset_stall) begin
      n = $urandom_range(0, 8);
      if (long_hold_req) begin
        n = 3000;
        long_hold_req = 1'b0;
      end
      hold = n;
      offset_stall <= (n > 0);
    end else begin
      offset_stall <= 1'b0;
    end
  end

  initial begin
    #20_000_000;
    $display("TB_ERROR");
    $finish;
  end

  initial begin
    longint lat, lon;
    int sel;
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    send_fix(0, 0);
    send_fix(0, 0);
    send_fix(900000000, 0);
    send_fix(-900000000, 0);
    send_fix(0, 1800000000);
    send_fix(0, -1800000000);
    send_fix(900000000, 1800000000);
    send_fix(-900000000, -1800000000);
    send_fix(1073741823, 2147483647);
    send_fix(-1073741824, -64'sd2147483648);
    send_fix(1000000000, 1);
    send_fix(-1000000000, -1);
    send_fix(1, 900000000);
    send_fix(-1, 1452516351);
    send_fix(450000000, 2000000000);
    send_fix(-450000000, -2000000000);
    send_fix(0, 1);
    send_fix(1, 0);
    for (int i = 0; i < 1950; i++) begin
      if (i == 300) long_hold_req = 1'b1;
      if (i == 1000) begin
        fix_valid <= 1'b0;
        @(posedge clk);
        wait (pending == 0);
        @(posedge clk);
      end
      sel = $urandom_range(0, 99);
      if (sel < 40) begin
        lat = srand(900000000);
        lon = srand(1800000000);
      end else if (sel < 70) begin
        lat = srand($urandom_range(1, 100000));
        lon = srand($urandom_range(1, 100000));
      end else if (sel < 85) begin
        lat = longint'($signed(31'($urandom)));
        lon = longint'($signed($urandom));
      end else begin
        lat = ($urandom_range(0, 1) ? 900000000 : -900000000) * $urandom_range(0, 1);
        lon = $urandom_range(0, 1) ? 0 : srand(1800000000);
      end
      send_fix(lat, lon);
    end
    fix_valid <= 1'b0;
    @(posedge clk);
    wait (pending == 0);
    repeat (600) @(posedge clk);
    if (errors == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule

[gps_fix_to_local_offset_top.f]
sv/gfl_pkg.sv
sv/gps_fix_to_local_offset_top.sv
bench/gfl_offset_checker.sv
bench/tb_gps_fix_to_local_offset_top.sv
